// ===== src/omi_pkg.sv =====
package omi_pkg;

	// configuration register indexes
	localparam logic REG_MODULUS     = 1'b0;
	localparam logic REG_NEG_INVERSE = 1'b1;

	// operand kinds
	localparam logic KIND_CLASSIC = 1'b0;
	localparam logic KIND_MONT    = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MODRED,
		ST_MR_MUL1,
		ST_MR_MUL2,
		ST_MR_SHIFT,
		ST_CORE_INIT,
		ST_CORE_STRIP_Y,
		ST_CORE_XSUB,
		ST_CORE_XSTRIP,
		ST_CORE_YSUB,
		ST_CORE_YSTRIP,
		ST_CORE_END,
		ST_RED_SETUP,
		ST_DONE
	} omi_state_t;

	// reduction return points
	typedef enum logic [1:0] {
		RET_MONT1,
		RET_MONT2,
		RET_CORE
	} omi_ret_t;

endpackage

// ===== src/omi_mul.sv =====
// 64x64 multiplier built from one 32x32 partial product per cycle
module omi_mul
	import omi_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] prod
);
	logic [2:0]   step_q;
	logic         busy_q;
	logic [63:0]  a_q, b_q;
	logic [127:0] acc_q;
	logic [31:0]  pa, pb;
	logic [63:0]  pp;
	logic [127:0] pp_sh;

	// select the partial product for this step
	always_comb begin
		pa = step_q[0] ? a_q[63:32] : a_q[31:0];
		pb = step_q[1] ? b_q[63:32] : b_q[31:0];
		pp = pa * pb;
		pp_sh = {64'd0, pp} << (7'(step_q[0] + step_q[1]) * 7'd32);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 3'd1;
			if (step_q == 3'd3) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	assign done = !busy_q && step_q == 3'd4;
	assign prod = acc_q;
endmodule

// ===== src/omi_ctrl.sv =====
// sequencer: modular reduction, binary extended GCD and Montgomery reductions
module omi_ctrl
	import omi_pkg::*;
#(
	parameter int WORD_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_kind,
	input  logic [WORD_BITS-1:0] in_operand,
	input  logic [WORD_BITS-1:0] modulus,
	input  logic [WORD_BITS-1:0] neg_inverse,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic [WORD_BITS-1:0] res_inverse,
	output logic                 res_ok
);
	localparam int W = WORD_BITS;
	localparam int TW = $clog2(2 * W + 2) + 1;
	localparam int CW = $clog2(W + 1);

	omi_state_t state_q, state_d;
	omi_ret_t   ret_q;

	logic [W-1:0]  x_q, y_q, u_q, v_q, a_q;
	logic [W-1:0]  rem_q;
	logic [CW-1:0] bit_q;
	logic [TW-1:0] t_q;
	logic          kind_q;
	logic [W-1:0]  r_q;
	logic          ok_q;
	logic          res_valid_q;

	// reduction operands
	logic [W-1:0]   mr_u_q, mr_q_q;
	logic [6:0]     mr_s_q;
	logic [127:0]   mr_sum_q;

	logic           mul_start;
	logic [63:0]    mul_a, mul_b;
	logic           mul_done;
	logic [127:0]   mul_p;

	omi_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.prod  (mul_p)
	);

	logic mul_wait_q;
	logic [W-1:0] smask;
	logic [127:0] sum_shift;
	logic [W-1:0] red_out;
	logic         mod_ok;
	logic         x_lsb0, y_lsb0;
	logic [W-1:0] xs, ys;
	logic [W:0]   rem_sh, rem_sub;

	always_comb begin
		smask = (mr_s_q >= 7'(W)) ? {W{1'b1}} : ~({W{1'b1}} << mr_s_q);
		sum_shift = mr_sum_q >> mr_s_q;
		red_out = sum_shift[W-1:0];
		mod_ok = (modulus >= W'(3)) && modulus[0];
		x_lsb0 = !x_q[0];
		y_lsb0 = !y_q[0];
		xs = x_q - y_q;
		ys = y_q - x_q;
		rem_sh = {rem_q, a_q[W-1]};
		rem_sub = rem_sh - {1'b0, modulus};
		mul_a = 64'(mr_u_q);
		mul_b = 64'(neg_inverse);
		if (state_q == ST_MR_MUL2) begin
			mul_a = 64'(mr_q_q);
			mul_b = 64'(modulus);
		end
	end

	assign mul_start = (state_q == ST_MR_MUL1 || state_q == ST_MR_MUL2) && !mul_wait_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:         if (in_valid && !res_valid_q) state_d = ST_CHECK;
			ST_CHECK: begin
				if (!mod_ok || a_q == '0) state_d = ST_DONE;
				else if (kind_q == KIND_CLASSIC)
					state_d = (a_q >= modulus) ? ST_MODRED : ST_CORE_INIT;
				else if (a_q < modulus) state_d = ST_MR_MUL1;
				else state_d = ST_DONE;
			end
			ST_MODRED:       if (bit_q == '0) state_d = ST_CORE_INIT;
			ST_MR_MUL1:      if (mul_wait_q && mul_done) state_d = ST_MR_MUL2;
			ST_MR_MUL2:      if (mul_wait_q && mul_done) state_d = ST_MR_SHIFT;
			ST_MR_SHIFT: begin
				unique case (ret_q)
					RET_MONT1: state_d = ST_MR_MUL1;
					RET_MONT2: state_d = ST_CORE_INIT;
					default:   state_d = ST_RED_SETUP;
				endcase
			end
			ST_CORE_INIT: begin
				if (y_q == '0) state_d = ST_DONE;
				else state_d = ST_CORE_STRIP_Y;
			end
			ST_CORE_STRIP_Y: if (!y_lsb0) state_d = ST_CORE_XSUB;
			ST_CORE_XSUB:    state_d = ST_CORE_XSTRIP;
			ST_CORE_XSTRIP: begin
				if (!x_lsb0) begin
					if (x_q > y_q) state_d = ST_CORE_XSUB;
					else if (x_q == y_q) state_d = ST_CORE_END;
					else state_d = ST_CORE_YSUB;
				end
			end
			ST_CORE_YSUB:    state_d = ST_CORE_YSTRIP;
			ST_CORE_YSTRIP: begin
				if (!y_lsb0) begin
					if (x_q < y_q) state_d = ST_CORE_YSUB;
					else if (x_q == y_q) state_d = ST_CORE_END;
					else state_d = ST_CORE_XSUB;
				end
			end
			ST_CORE_END:     state_d = (x_q > W'(1)) ? ST_DONE : ST_RED_SETUP;
			ST_RED_SETUP:    state_d = (t_q == '0) ? ST_DONE : ST_MR_MUL1;
			ST_DONE:         state_d = ST_IDLE;
			default:         state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// handshake registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			mul_wait_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
			if (mul_start) mul_wait_q <= 1'b1;
			else if (mul_done) mul_wait_q <= 0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				// hold the finished result until the master takes it
				if (!res_valid_q) begin
					a_q <= in_operand;
					kind_q <= in_kind;
					ok_q <= 1'b0;
					r_q <= '0;
				end
			end
			ST_CHECK: begin
				y_q <= a_q;
				rem_q <= '0;
				bit_q <= CW'(W);
				mr_u_q <= a_q;
				mr_s_q <= 7'(W);
				ret_q <= RET_MONT1;
			end
			ST_MODRED: begin
				// restoring division, one quotient bit per cycle
				if (bit_q != '0) begin
					if (rem_sh >= {1'b0, modulus})
						rem_q <= rem_sub[W-1:0];
					else
						rem_q <= rem_sh[W-1:0];
					a_q <= a_q << 1;
					bit_q <= bit_q - CW'(1);
				end else begin
					y_q <= rem_q;
				end
			end
			ST_MR_MUL1: if (mul_wait_q && mul_done) mr_q_q <= mul_p[W-1:0] & smask;
			ST_MR_MUL2: if (mul_wait_q && mul_done) mr_sum_q <= mul_p + 128'(mr_u_q);
			ST_MR_SHIFT: begin
				unique case (ret_q)
					RET_MONT1: begin
						mr_u_q <= red_out;
						ret_q <= RET_MONT2;
					end
					RET_MONT2: y_q <= (red_out >= modulus) ? red_out - modulus : red_out;
					default: u_q <= red_out;
				endcase
			end
			ST_CORE_INIT: begin
				x_q <= modulus;
				u_q <= W'(1);
				v_q <= '0;
				t_q <= '0;
			end
			ST_CORE_STRIP_Y: if (y_lsb0) begin
				y_q <= y_q >> 1;
				t_q <= t_q + TW'(1);
			end
			ST_CORE_XSUB: begin
				x_q <= xs;
				v_q <= v_q + u_q;
			end
			ST_CORE_XSTRIP: if (x_lsb0) begin
				x_q <= x_q >> 1;
				u_q <= u_q << 1;
				t_q <= t_q + TW'(1);
			end
			ST_CORE_YSUB: begin
				y_q <= ys;
				u_q <= u_q + v_q;
			end
			ST_CORE_YSTRIP: if (y_lsb0) begin
				y_q <= y_q >> 1;
				v_q <= v_q << 1;
				t_q <= t_q + TW'(1);
			end
			ST_CORE_END: if (!u_q[0]) u_q <= modulus - v_q;
			ST_RED_SETUP: begin
				ret_q <= RET_CORE;
				mr_u_q <= u_q;
				if (t_q >= TW'(W)) begin
					mr_s_q <= 7'(W);
					t_q <= t_q - TW'(W);
				end else begin
					mr_s_q <= 7'(t_q);
					t_q <= '0;
				end
				if (t_q == '0) begin
					r_q <= u_q;
					ok_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE) && !res_valid_q;
	assign res_valid = res_valid_q;
	assign res_inverse = ok_q ? r_q : '0;
	assign res_ok = ok_q;
endmodule

// ===== src/odd_modulus_inverse_64_top.sv =====
// Modular inverse modulo a configured odd modulus m.
// Slave stream: tdata = operand, tuser = kind (0 classical, 1 Montgomery).
// Master stream: tdata = inverse, tuser = ok; inverse is zero when ok is 0.
// Config channel: cfg_index 0 writes modulus, 1 writes neg_inverse (-1/m
// mod 2^WORD_BITS); write only while idle.
// One item at a time: s_tready rises after the previous result is taken.
// Latency is data dependent: a bit-serial remainder for classical operands
// at or above m, a subtract state and then a strip-and-compare state per
// subtract of the binary GCD, with a strip step per stripped zero bit, and
// the Montgomery reductions (each final one after a setup state), each done
// on a shared multiplier taking four 32x32 partial products.
// A stalled master holds the result and blocks the next input.
// Reset sets modulus to 3 and neg_inverse to 0x5555...; no item in flight.
module odd_modulus_inverse_64_top
	import omi_pkg::*;
#(
	parameter int WORD_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // operand
	input  logic        s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // inverse
	output logic        m_tuser,   // ok
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);
	localparam logic [63:0] NINV_RESET = 64'h5555555555555555;

	logic [WORD_BITS-1:0] modulus_q, neg_inverse_q, inv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= WORD_BITS'(3);
			neg_inverse_q <= NINV_RESET[WORD_BITS-1:0];
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_NEG_INVERSE) neg_inverse_q <= cfg_data[WORD_BITS-1:0];
			else modulus_q <= cfg_data[WORD_BITS-1:0];
		end
	end
	assign cfg_ready = 1'b1;

	omi_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_kind    (s_tuser),
		.in_operand (s_tdata[WORD_BITS-1:0]),
		.modulus    (modulus_q),
		.neg_inverse(neg_inverse_q),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res_inverse(inv),
		.res_ok     (m_tuser)
	);
	assign m_tdata = 64'(inv);
endmodule

// ===== test/odd_modulus_inverse_64_checker.sv =====
module odd_modulus_inverse_64_checker
	import omi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,   // operand
	input  logic        s_tuser,   // kind
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,   // inverse
	input  logic        m_tuser,   // ok
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	output int          failures,
	output int          pending
);

	typedef struct {
		logic [63:0] inverse;
		logic        ok;
	} inv_result_t;

	logic [63:0] modulus;
	logic [63:0] neg_inv;
	inv_result_t inverse_q[$];

	// (u + q*m) >> s with q = u*neg_inv mod 2^s
	function automatic logic [63:0] mont_reduce(logic [63:0] u, int s);
		logic [63:0]  q;
		logic [128:0] sum;
		q = u * neg_inv;
		if (s < 64)
			q = q & ((64'd1 << s) - 64'd1);
		sum = 129'(q) * 129'(modulus) + 129'(u);
		return 64'(sum >> s);
	endfunction

	function automatic int low_zeros(logic [63:0] x);
		int n;
		n = 0;
		while (n < 64 && !x[n])
			n++;
		return n;
	endfunction

	// binary extended gcd on y in (0, m), then strip 2^t
	function automatic logic gcd_invert(logic [63:0] y, output logic [63:0] r);
		logic [63:0] x, u, v;
		int t, sh;
		x = modulus;
		u = 64'd1;
		v = 64'd0;
		r = 64'd0;
		sh = low_zeros(y);
		y = y >> sh;
		t = sh;
		do begin
			do begin
				x = x - y;
				v = v + u;
				sh = low_zeros(x);
				x = x >> sh;
				t += sh;
				u = u << sh;
			end while (x > y);
			if (x == y)
				break;
			do begin
				y = y - x;
				u = u + v;
				sh = low_zeros(y);
				y = y >> sh;
				t += sh;
				v = v << sh;
			end while (x < y);
		end while (x != y);
		if (x > 64'd1)
			return 1'b0;
		if (!u[0])
			u = modulus - v;
		while (t >= 64) begin
			u = mont_reduce(u, 64);
			t -= 64;
		end
		if (t > 0)
			u = mont_reduce(u, t);
		r = u;
		return 1'b1;
	endfunction

	function automatic inv_result_t predict_inverse(logic kind, logic [63:0] a);
		inv_result_t res;
		logic [63:0] y;
		res.inverse = 64'd0;
		res.ok = 1'b0;
		if (modulus >= 64'd3 && modulus[0] && a != 64'd0) begin
			if (kind == KIND_CLASSIC) begin
				y = (a >= modulus) ? a % modulus : a;
				if (y != 64'd0)
					res.ok = gcd_invert(y, res.inverse);
			end else if (a < modulus) begin
				y = mont_reduce(mont_reduce(a, 64), 64);
				if (y >= modulus)
					y = y % modulus;
				if (y != 64'd0)
					res.ok = gcd_invert(y, res.inverse);
			end
		end
		if (!res.ok)
			res.inverse = 64'd0;
		return res;
	endfunction

	// track registers, queue expectations, compare results
	always @(posedge clk or negedge arst_n) begin
		inv_result_t want;
		int errs;
		if (!arst_n) begin
			modulus <= 64'd3;
			neg_inv <= 64'h5555_5555_5555_5555;
			inverse_q.delete();
			failures <= 0;
			pending <= 0;
		end else begin
			errs = 0;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MODULUS)
					modulus <= cfg_data;
				else if (cfg_index == REG_NEG_INVERSE)
					neg_inv <= cfg_data;
			end
			if (s_tvalid && s_tready)
				inverse_q.push_back(predict_inverse(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				if (inverse_q.size() == 0) begin
					$error("unexpected result beat: inverse %h ok %b", m_tdata, m_tuser);
					errs++;
				end else begin
					want = inverse_q.pop_front();
					if (m_tdata !== want.inverse) begin
						$error("inverse: expected %h, actual %h", want.inverse, m_tdata);
						errs++;
					end
					if (m_tuser !== want.ok) begin
						$error("ok: expected %b, actual %b", want.ok, m_tuser);
						errs++;
					end
				end
			end
			failures <= failures + errs;
			pending <= inverse_q.size();
		end
	end

endmodule

// ===== test/odd_modulus_inverse_64_top_test.sv =====
module odd_modulus_inverse_64_top_test
	import omi_pkg::*;
();

	localparam int   NUM_PHASES      = 13;
	localparam int   PHASE_ITEMS     = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = 64'd0;   // operand
	logic        s_tuser = 1'b0;    // kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;           // inverse
	logic        m_tuser;           // ok
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [63:0] cfg_data = 64'd0;

	int failures;
	int pending;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_req = 0;
	logic [63:0] cur_modulus = 64'd3;

	odd_modulus_inverse_64_top dut (.*);

	odd_modulus_inverse_64_checker chk (.*);

	always #10 clk = ~clk;

	// receiver: random stall, or a long hold-off when requested
	always @(negedge clk) begin
		static int hold_seen = 0;
		static int hold_left = 0;
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = 3000;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	initial begin
		#400_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// called at a falling edge; returns at a falling edge after the beat
	task automatic send_operand(logic kind, logic [63:0] op);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0 || s_tvalid)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// -1/m mod 2^64 by Newton iteration
	function automatic logic [63:0] neg_inverse_of(logic [63:0] m);
		logic [63:0] inv;
		inv = m;
		repeat (6)
			inv = inv * (64'd2 - m * inv);
		return -inv;
	endfunction

	function automatic logic [63:0] rand64;
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] random_operand(logic kind);
		int pick;
		logic [63:0] v;
		pick = $urandom_range(9);
		case (pick)
			0: v = 64'($urandom_range(16));
			1: v = cur_modulus - 64'($urandom_range(3));
			2: v = cur_modulus * 64'($urandom_range(5));
			3: v = rand64() >> $urandom_range(63);
			default: v = rand64();
		endcase
		// Montgomery operands mostly below m so the reductions get exercised
		if (kind == KIND_MONT && pick >= 3 && $urandom_range(9) != 0 && cur_modulus > 64'd1)
			v = v % cur_modulus;
		return v;
	endfunction

	task automatic configure(int phase);
		logic [63:0] m;
		logic [63:0] ni;
		case (phase)
			1: m = 64'hFFFF_FFFF_FFFF_FFFF;
			2: m = 64'hFFFF_FFFF_FFFF_FFC5;
			3: m = 64'd15;
			4: m = 64'd10;
			5: m = 64'd1;
			6: m = 64'h8000_0000_0000_0001;
			7: m = 64'd7;
			8: m = 64'h0000_0001_0000_000F;
			default: m = rand64() | 64'd1;
		endcase
		ni = neg_inverse_of(m);
		// deliberately wrong reduction constant
		if (phase == 10)
			ni = rand64();
		write_reg(REG_MODULUS, m);
		write_reg(REG_NEG_INVERSE, ni);
		cur_modulus = m;
	endtask

	initial begin
		logic kind;
		logic [63:0] directed[$];
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// field extremes and special cases with reset modulus 3
		directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd6,
			64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA};
		foreach (directed[i])
			send_operand(KIND_CLASSIC, directed[i]);
		foreach (directed[i])
			send_operand(KIND_MONT, directed[i]);
		drain();

		// composite modulus: common factors and zero residues
		configure(3);
		foreach (directed[i])
			send_operand(i[0] ? KIND_MONT : KIND_CLASSIC, directed[i] % 64'd20);
		send_operand(KIND_CLASSIC, 64'd5);
		send_operand(KIND_MONT, 64'd14);
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p != 0)
				configure(p);
			case (p % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
				default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// long receiver hold-off while items keep coming
				if (p == 2 && i == 10)
					hold_req <= hold_req + 1;
				// sender pause until everything has come back
				if (i == 75)
					drain();
				kind = $urandom_range(1);
				send_operand(kind, random_operand(kind));
			end
			drain();
		end

		tx_idle_pct = 0;
		repeat (200) @(negedge clk);
		if (failures == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== odd_modulus_inverse_64_top.f =====
src/omi_pkg.sv
src/omi_mul.sv
src/omi_ctrl.sv
src/odd_modulus_inverse_64_top.sv
test/odd_modulus_inverse_64_checker.sv
test/odd_modulus_inverse_64_top_test.sv
